>>> hw/rtl/rlol_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rlol_pkg
// shared types and constants of the ring log with byte offset lookup
// ----------------------------------------------------------------------------
package rlol_pkg;

  localparam int SLOTS = 16;
  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);

  localparam int HANDLE_W = 32;
  localparam int SIZE_W   = 16;
  localparam int POS_W    = 20;
  localparam int SLOT_W   = 4;

  // request kinds
  localparam logic REQ_ADD  = 1'b0;
  localparam logic REQ_FIND = 1'b1;

  typedef struct packed {
    logic                req_type;
    logic [HANDLE_W-1:0] entry_handle;
    logic [SIZE_W-1:0]   entry_size;
    logic [POS_W-1:0]    lookup_pos;
  } req_t;

  typedef struct packed {
    logic                found;
    logic [SLOT_W-1:0]   slot;
    logic [HANDLE_W-1:0] hit_handle;
    logic [SIZE_W-1:0]   hit_size;
    logic [SIZE_W-1:0]   byte_offset;
  } rsp_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [SIZE_W-1:0]   size;
  } entry_t;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_t;

endpackage : rlol_pkg
`default_nettype wire

>>> hw/rtl/ring_log_offset_lookup.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ring_log_offset_lookup
// ring of handle/length entries with a search by byte offset
// ----------------------------------------------------------------------------
// An add request writes its entry into the ring, overwriting the oldest entry
// once all SLOTS slots hold data. A find request is accepted and then walks the
// entries from the oldest on through the entry ram, which returns one entry per
// cycle on its single read port while the result register is free. While a
// find walks, no new request is taken. The result sits in an output register,
// so the next request is accepted while a result waits to be taken. The ram
// needs no clearing after reset: only written entries are ever visited.
// ----------------------------------------------------------------------------
module ring_log_offset_lookup
  import rlol_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,

  input  wire logic in_valid,
  output logic      in_stall,
  input  wire req_t in_data,

  output logic      out_valid,
  input  wire logic out_stall,
  output rsp_t      out_data
);

  function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i);
    if (i == IDX_W'(SLOTS - 1)) begin
      return '0;
    end
    return i + 1'b1;
  endfunction

  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  wr_idx_r, wr_idx_nxt;
  logic [IDX_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic              full_r, full_nxt;
  logic [IDX_W-1:0]  chk_idx_r, chk_idx_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic              out_valid_r, out_valid_nxt;
  rsp_t              out_r, out_nxt;

  logic              accept;
  logic              step;
  logic              hit;
  logic              fin;
  logic [CNT_W-1:0]  count;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_raddr;
  entry_t            ram_wdata;
  entry_t            ram_rdata;

  rlol_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_idx_r),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign accept = in_valid && !in_stall;
  // result register free this cycle
  assign step   = !out_valid_r || !out_stall;
  assign hit    = (rem_r != '0) && (pos_r < {{(POS_W-SIZE_W){1'b0}}, ram_rdata.size});
  assign fin    = (rem_r == '0) || (rem_r == CNT_W'(1)) || hit;

  always_comb begin
    if (full_r) begin
      count = CNT_W'(SLOTS);
    end else if (wr_idx_r >= rd_idx_r) begin
      count = CNT_W'(wr_idx_r) - CNT_W'(rd_idx_r);
    end else begin
      count = CNT_W'(wr_idx_r) + CNT_W'(SLOTS) - CNT_W'(rd_idx_r);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_data.req_type == REQ_FIND) begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (step && fin) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    in_stall      = (state_r != ST_IDLE);
    ram_we        = 1'b0;
    ram_wdata     = '{handle: in_data.entry_handle, size: in_data.entry_size};
    ram_raddr     = rd_idx_r;
    wr_idx_nxt    = wr_idx_r;
    rd_idx_nxt    = rd_idx_r;
    full_nxt      = full_r;
    chk_idx_nxt   = chk_idx_r;
    rem_nxt       = rem_r;
    pos_nxt       = pos_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_data.req_type == REQ_ADD) begin
            ram_we     = 1'b1;
            wr_idx_nxt = next_slot(wr_idx_r);
            full_nxt   = full_r || (next_slot(wr_idx_r) == rd_idx_r);
            if (full_nxt) begin
              rd_idx_nxt = next_slot(wr_idx_r);
            end
          end else begin
            // oldest entry is being read this cycle
            chk_idx_nxt = rd_idx_r;
            rem_nxt     = count;
            pos_nxt     = in_data.lookup_pos;
          end
        end
      end
      ST_WALK: begin
        ram_raddr = step ? next_slot(chk_idx_r) : chk_idx_r;
        if (step) begin
          if (fin) begin
            out_valid_nxt = 1'b1;
            if (hit) begin
              out_nxt = '{found:       1'b1,
                          slot:        SLOT_W'(chk_idx_r),
                          hit_handle:  ram_rdata.handle,
                          hit_size:    ram_rdata.size,
                          byte_offset: pos_r[SIZE_W-1:0]};
            end else begin
              out_nxt = '0;
            end
          end else begin
            pos_nxt     = pos_r - {{(POS_W-SIZE_W){1'b0}}, ram_rdata.size};
            rem_nxt     = rem_r - 1'b1;
            chk_idx_nxt = next_slot(chk_idx_r);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wr_idx_r    <= '0;
      rd_idx_r    <= '0;
      full_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wr_idx_r    <= wr_idx_nxt;
      rd_idx_r    <= rd_idx_nxt;
      full_r      <= full_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_idx_r <= chk_idx_nxt;
    rem_r     <= rem_nxt;
    pos_r     <= pos_nxt;
    out_r     <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // the ring must not change under a walk
  a_no_write_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WALK |-> !ram_we)
    else $error("entry ram written during a walk");

  a_rd_zero_until_full: assert property (@(posedge clk) disable iff (!rst_n)
    !full_r |-> rd_idx_r == '0)
    else $error("read index moved before the ring filled");

  a_rd_follows_wr: assert property (@(posedge clk) disable iff (!rst_n)
    full_r |-> rd_idx_r == wr_idx_r)
    else $error("read index does not follow write index in a full ring");

  a_hit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.found |-> out_r.byte_offset < out_r.hit_size)
    else $error("found result with offset beyond the entry");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.found |-> out_r == '0)
    else $error("not found result carries data");

endmodule : ring_log_offset_lookup
`default_nettype wire

>>> hw/rtl/rlol_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rlol_ram
// simple dual port ram, one write port, one read port with registered data
// ----------------------------------------------------------------------------
module rlol_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule : rlol_ram
`default_nettype wire

>>> dv/tb_ring_log_offset_lookup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ring_log_offset_lookup
// self-checking bench for the ring log with byte offset lookup: add and find
// requests go in through the valid/stall request channel, a local copy of the
// ring predicts every find result, and each result is compared field by field
// in order of arrival, in some phases under random gaps on the request side and random stall
// bursts on the result side
// ----------------------------------------------------------------------------
module tb_ring_log_offset_lookup
  import rlol_pkg::*;
();

  localparam int CLK_HALF    = 6;
  localparam int RST_CYCLES  = 11;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 2 * SLOTS + 8;
  localparam int MAX_SIZE    = (1 << SIZE_W) - 1;
  localparam int MAX_POS     = (1 << POS_W) - 1;

  logic clk;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_stall;
  req_t in_data   = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rsp_t out_data;

  // local copy of the ring contents and pointers
  logic [HANDLE_W-1:0] handle_mem [SLOTS];
  logic [SIZE_W-1:0]   size_mem   [SLOTS];
  int                  wr_ptr      = 0;
  int                  rd_ptr      = 0;
  bit                  ring_full_q = 1'b0;

  rsp_t lookup_q [$];
  int   err_cnt    = 0;
  int   cycle_cnt  = 0;
  int   stall_hold = 0;
  bit   idle_on    = 1'b1;

  ring_log_offset_lookup u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #CLK_HALF;
    clk = 1'b1;
    #CLK_HALF;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void log_append(logic [HANDLE_W-1:0] h, logic [SIZE_W-1:0] s);
    handle_mem[wr_ptr] = h;
    size_mem[wr_ptr]   = s;
    wr_ptr = (wr_ptr + 1) % SLOTS;
    if (wr_ptr == rd_ptr) ring_full_q = 1'b1;
    // once full the oldest entry is dropped on every add
    if (ring_full_q) rd_ptr = wr_ptr;
  endfunction

  function automatic int live_count();
    return ring_full_q ? SLOTS : (wr_ptr + SLOTS - rd_ptr) % SLOTS;
  endfunction

  // bytes held by the n oldest entries
  function automatic int unsigned prefix_bytes(int n);
    int unsigned sum;
    sum = 0;
    for (int k = 0; k < n; k++) sum += size_mem[(rd_ptr + k) % SLOTS];
    return sum;
  endfunction

  function automatic rsp_t offset_lookup(logic [POS_W-1:0] off);
    rsp_t        hit;
    int unsigned pos;
    int          idx;
    int          live;
    hit  = '0;
    pos  = off;
    idx  = rd_ptr;
    live = live_count();
    for (int k = 0; k < live; k++) begin
      if (pos < size_mem[idx]) begin
        hit.found       = 1'b1;
        hit.slot        = SLOT_W'(idx);
        hit.hit_handle  = handle_mem[idx];
        hit.hit_size    = size_mem[idx];
        hit.byte_offset = SIZE_W'(pos);
        return hit;
      end
      pos -= size_mem[idx];
      idx = (idx + 1) % SLOTS;
    end
    return hit;
  endfunction

  // ---------------------------------------------------------------- requests

  function automatic req_t add_item(logic [HANDLE_W-1:0] h, logic [SIZE_W-1:0] s);
    req_t r;
    r.req_type     = REQ_ADD;
    r.entry_handle = h;
    r.entry_size   = s;
    r.lookup_pos   = POS_W'($urandom);
    return r;
  endfunction

  function automatic req_t find_item(logic [POS_W-1:0] off);
    req_t r;
    r.req_type     = REQ_FIND;
    r.entry_handle = $urandom;
    r.entry_size   = SIZE_W'($urandom);
    r.lookup_pos   = off;
    return r;
  endfunction

  task automatic send_req(input req_t r);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (r.req_type == REQ_FIND) lookup_q.push_back(offset_lookup(r.lookup_pos));
    else log_append(r.entry_handle, r.entry_size);
  endtask

  task automatic wait_results_done();
    in_valid <= 1'b0;
    do @(posedge clk); while (lookup_q.size() != 0);
  endtask

  // ---------------------------------------------------------------- result side

  always @(posedge clk) begin
    if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else if (idle_on && $urandom_range(0, 2) == 0) begin
      out_stall  <= 1'b1;
      stall_hold <= $urandom_range(0, 8);
    end else begin
      out_stall  <= 1'b0;
      stall_hold <= $urandom_range(0, 15);
    end
  end

  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", field, want, got);
      err_cnt++;
    end
  endfunction

  always @(posedge clk) begin : rsp_check
    rsp_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (lookup_q.size() == 0) begin
        $error("lookup result with none pending: %p", out_data);
        err_cnt++;
      end else begin
        want = lookup_q.pop_front();
        check_field("found", want.found, out_data.found);
        check_field("slot", want.slot, out_data.slot);
        check_field("hit_handle", want.hit_handle, out_data.hit_handle);
        check_field("hit_size", want.hit_size, out_data.hit_size);
        check_field("byte_offset", want.byte_offset, out_data.byte_offset);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb_ring_log_offset_lookup failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_empty_ring();
    send_req(find_item('0));
    send_req(find_item(POS_W'(MAX_POS)));
  endtask

  // zero-length entry first, then the largest entry, then a one byte entry
  task automatic test_partial_ring();
    send_req(add_item('0, '0));
    send_req(add_item('1, '1));
    send_req(add_item(32'h5a5a_a5a5, SIZE_W'(1)));
    send_req(find_item('0));
    send_req(find_item(POS_W'(MAX_SIZE - 1)));
    send_req(find_item(POS_W'(MAX_SIZE)));
    send_req(find_item(POS_W'(MAX_SIZE + 1)));
    send_req(find_item(POS_W'(MAX_POS)));
  endtask

  // fill past the end so the oldest entry is overwritten
  task automatic test_ring_wrap();
    int unsigned total;
    for (int k = 0; k < SLOTS - 2; k++) send_req(add_item($urandom, '1));
    total = prefix_bytes(live_count());
    send_req(find_item(POS_W'(total - 1)));
    send_req(find_item(POS_W'(total)));
    send_req(find_item(POS_W'(MAX_SIZE)));
  endtask

  // every slot at full length, so a find walks the whole ring near the top offset
  task automatic test_max_size_walk();
    int unsigned total;
    for (int k = 0; k < SLOTS; k++) send_req(add_item($urandom, '1));
    total = prefix_bytes(live_count());
    send_req(find_item(POS_W'(total - 1)));
    send_req(find_item(POS_W'(total)));
    send_req(find_item(POS_W'(MAX_POS)));
    for (int k = 0; k < 6; k++) send_req(find_item(POS_W'($urandom_range(0, total - 1))));
  endtask

  task automatic test_random_traffic(input int n_items, input bit with_idle, input bit with_drain);
    int unsigned       total;
    int unsigned       off;
    int                live;
    int                k;
    logic [SIZE_W-1:0] sz;
    idle_on = with_idle;
    for (int i = 0; i < n_items; i++) begin
      if (with_drain && i % 160 == 159) wait_results_done();
      live  = live_count();
      total = prefix_bytes(live);
      if ($urandom_range(0, 99) < 45) begin
        case ($urandom_range(0, 9))
          0:          sz = '0;
          1, 2:       sz = '1;
          3, 4, 5, 6: sz = SIZE_W'($urandom_range(1, 512));
          default:    sz = SIZE_W'($urandom);
        endcase
        send_req(add_item($urandom, sz));
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: begin
            off = (total == 0) ? 0 : $urandom_range(0, total - 1);
          end
          // right on an entry boundary or one byte short of it
          5, 6: begin
            k   = $urandom_range(1, (live > 0) ? live : 1);
            off = prefix_bytes(k) - $urandom_range(0, 1);
          end
          7:       off = $urandom_range(total, MAX_POS);
          default: off = $urandom;
        endcase
        send_req(find_item(POS_W'(off)));
      end
    end
  endtask

  initial begin
    repeat (RST_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_ring();
    test_partial_ring();
    test_ring_wrap();
    test_random_traffic(500, 1'b1, 1'b0);
    test_max_size_walk();
    test_random_traffic(400, 1'b0, 1'b0);
    test_random_traffic(500, 1'b1, 1'b1);
    test_random_traffic(200, 1'b0, 1'b0);
    wait_results_done();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("tb_ring_log_offset_lookup passed");
    end else begin
      $display("tb_ring_log_offset_lookup failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/rlol_pkg.sv
hw/rtl/rlol_ram.sv
hw/rtl/ring_log_offset_lookup.sv
dv/tb_ring_log_offset_lookup.sv
